// File: rtl/cmc_pkg.sv
`timescale 1ns / 1ps

package cmc_pkg;

    // defaults for the top level parameters
    localparam int DEF_BLOCK_INDEX_BITS = 16;
    localparam int DEF_COUNT_WIDTH      = 32;

    // fixed field widths
    localparam int OPCODE_W    = 4;
    localparam int ADDR_W      = 32;
    localparam int CLASS_W     = 2;
    localparam int OUT_COUNT_W = 32;
    localparam int STATUS_W    = 2;
    localparam int BSL_W       = 4;
    localparam int CFG_DATA_W  = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam int NUM_COUNTERS = 24;
    localparam int CNT_IDX_W    = 5;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_FETCH      = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_UPGRADE    = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_EVICT_LAST = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_RETURN     = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_DOWNGRADE  = 4'd9;

    // miss classes
    localparam logic [CLASS_W-1:0] CLS_NONE  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_COLD  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_COH   = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_REPL  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_OP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

    // configuration register indexes
    localparam logic CFG_ENABLE     = 1'b0;
    localparam logic CFG_BLOCK_SIZE = 1'b1;

    // block mark bits
    localparam logic [1:0] MARK_SEEN   = 2'b01;
    localparam logic [1:0] MARK_PROBED = 2'b10;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic lookup;
        logic update;
    } cmc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } cmc_stat_t;

endpackage

// File: rtl/cmc_ctrl.sv
`timescale 1ns / 1ps

module cmc_ctrl
    import cmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  cmc_stat_t stat,
    output cmc_cmd_t  cmd
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_LOOKUP = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.clear_step = 1'b0;
        cmd.capture    = 1'b0;
        cmd.lookup     = 1'b0;
        cmd.update     = 1'b0;
        s_tready       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // wait for room in the output register
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/cmc_datapath.sv
`timescale 1ns / 1ps

module cmc_datapath
    import cmc_pkg::*;
#(
    parameter int BLOCK_INDEX_BITS = DEF_BLOCK_INDEX_BITS,
    parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [OPCODE_W-1:0]    in_opcode,
    input  logic [ADDR_W-1:0]      in_address,
    input  logic                   in_privileged,
    input  cmc_cmd_t               cmd,
    output cmc_stat_t              stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH = 1 << BLOCK_INDEX_BITS;

    // configuration
    logic             enable_reg;
    logic [BSL_W-1:0] bsl_reg;

    // captured message
    logic [OPCODE_W-1:0]         op_reg;
    logic [BLOCK_INDEX_BITS-1:0] blk_reg;
    logic                        priv_reg;
    logic                        bad_op_reg;
    logic                        oor_reg;
    logic [1:0]                  mark_rd_reg;

    // clearing pass address
    logic [BLOCK_INDEX_BITS-1:0] clr_addr_reg;

    logic [1:0] marks_mem [DEPTH];

    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_COUNTERS];

    logic                   out_valid_reg;
    logic [CLASS_W-1:0]     out_class_reg;
    logic [OUT_COUNT_W-1:0] out_count_reg;
    logic [STATUS_W-1:0]    out_status_reg;

    logic [ADDR_W-1:0]           shifted;
    logic                        table_ok;
    logic                        is_req;
    logic [CLASS_W-1:0]          cls;
    logic [1:0]                  cls_m1;
    logic [1:0]                  mark_new;
    logic [CNT_IDX_W-1:0]        cnt_idx;
    logic [COUNT_WIDTH-1:0]      cnt_inc;
    logic [63:0]                 cnt_ext;
    logic                        mem_we;
    logic [BLOCK_INDEX_BITS-1:0] mem_waddr;
    logic [1:0]                  mem_wdata;
    logic [STATUS_W-1:0]         status_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            bsl_reg    <= 4'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:     enable_reg <= cfg_data[0];
                CFG_BLOCK_SIZE: bsl_reg    <= cfg_data[BSL_W-1:0];
                default:        enable_reg <= enable_reg;
            endcase
        end
    end

    assign shifted = in_address >> bsl_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= in_opcode;
            blk_reg    <= shifted[BLOCK_INDEX_BITS-1:0];
            priv_reg   <= in_privileged;
            bad_op_reg <= in_opcode > OP_DOWNGRADE;
            oor_reg    <= |shifted[ADDR_W-1:BLOCK_INDEX_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign stat.clear_last = &clr_addr_reg;
    assign stat.out_free   = !out_valid_reg || m_tready;

    // classification of the looked-up mark
    assign table_ok = enable_reg && !bad_op_reg && !oor_reg;
    assign is_req   = op_reg <= OP_UPGRADE;

    always_comb
    begin
        if ((mark_rd_reg & MARK_SEEN) == 2'b00)
        begin
            cls = CLS_COLD;
        end
        else if ((mark_rd_reg & MARK_PROBED) != 2'b00)
        begin
            cls = CLS_COH;
        end
        else
        begin
            cls = CLS_REPL;
        end

        if (op_reg <= OP_EVICT_LAST)
        begin
            mark_new = MARK_SEEN;
        end
        else if (op_reg == OP_RETURN)
        begin
            mark_new = mark_rd_reg | MARK_SEEN;
        end
        else
        begin
            mark_new = MARK_SEEN | MARK_PROBED;
        end

        if (!enable_reg)
        begin
            status_val = ST_OK;
        end
        else if (bad_op_reg)
        begin
            status_val = ST_BAD_OP;
        end
        else if (oor_reg)
        begin
            status_val = ST_RANGE;
        end
        else
        begin
            status_val = ST_OK;
        end
    end

    // counter index = kind*6 + (class-1)*2 + privileged
    assign cls_m1  = cls - 2'd1;
    assign cnt_idx = CNT_IDX_W'({3'b000, op_reg[1:0]} * 5'd6)
                   + {2'b00, cls_m1, 1'b0}
                   + {4'b0000, priv_reg};
    assign cnt_inc = cnt_reg[cnt_idx] + 1'b1;
    assign cnt_ext = 64'(cnt_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.update && table_ok && is_req)
        begin
            cnt_reg[cnt_idx] <= cnt_inc;
        end
    end

    // mark table
    assign mem_we    = cmd.clear_step || (cmd.update && table_ok);
    assign mem_waddr = cmd.clear_step ? clr_addr_reg : blk_reg;
    assign mem_wdata = cmd.clear_step ? 2'b00 : mark_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            marks_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.lookup)
        begin
            mark_rd_reg <= marks_mem[blk_reg];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_status_reg <= status_val;
            if (table_ok && is_req)
            begin
                out_class_reg <= cls;
                out_count_reg <= cnt_ext[OUT_COUNT_W-1:0];
            end
            else
            begin
                out_class_reg <= CLS_NONE;
                out_count_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_status_reg, out_count_reg, out_class_reg};

endmodule

// File: rtl/cache_miss_classifier_unit.sv
`timescale 1ns / 1ps

// cache miss classifier: each message beat on the slave side gives one result beat
// on the master side, classifying fetch, read, write and upgrade requests as cold,
// coherence or replacement and returning the updated class counter. an accepted
// beat steps through accept, a registered read of the single-port mark table and an
// update that waits for room in the output register, which lets the next beat be
// accepted while a result still waits. after reset the mark table is cleared one
// entry a cycle, so s_tready stays low until all 2^BLOCK_INDEX_BITS entries (65536
// by default) are cleared; configuration writes are taken during that pass.
module cache_miss_classifier_unit
    import cmc_pkg::*;
#(
    parameter int BLOCK_INDEX_BITS = DEF_BLOCK_INDEX_BITS,
    parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // message beats
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // address[31:0], privileged[32], zero pad
    input  logic [OPCODE_W-1:0]    s_tuser,   // opcode[3:0]
    // result beats
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // miss_class[1:0], class_count[33:2],
                                              // status[35:34], zero pad
);

    cmc_cmd_t  cmd;
    cmc_stat_t stat;

    // sequencing: clearing pass, idle, table read, update
    cmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // config registers, mark table, counters and output register
    cmc_datapath #(
        .BLOCK_INDEX_BITS (BLOCK_INDEX_BITS),
        .COUNT_WIDTH      (COUNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_opcode     (s_tuser),
        .in_address    (s_tdata[ADDR_W-1:0]),
        .in_privileged (s_tdata[ADDR_W]),
        .cmd           (cmd),
        .stat          (stat),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

// File: rtl/cmc_checker.sv
`timescale 1ns / 1ps

module cmc_checker
    import cmc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // one message at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat accepted while previous message still in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    // unclassified results carry a zero count
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == CLS_NONE) |-> (m_tdata[33:2] == 32'd0))
        else $error("count without classification");

    // classified results only with ok status
    a_class_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != CLS_NONE) |-> (m_tdata[35:34] == ST_OK))
        else $error("classification with error status");

    // status code is never the unused value
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35:34] != 2'd3))
        else $error("undefined status code");

endmodule

bind cache_miss_classifier_unit cmc_checker u_cmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
